// ===== hdl/qmn_pkg.sv =====
// Shared constants for the quaternion multiply and normalize core.
package qmn_pkg;

  localparam int N_LANE = 4;
  localparam int N_TERM = 4;

  // Component index of A and B for each term of each output lane (w, x, y, z).
  localparam logic [1:0] A_SEL [N_LANE][N_TERM] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd2, 2'd3, 2'd1},
    '{2'd0, 2'd3, 2'd1, 2'd2}
  };
  localparam logic [1:0] B_SEL [N_LANE][N_TERM] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd2, 2'd0, 2'd1, 2'd3},
    '{2'd3, 2'd0, 2'd2, 2'd1}
  };
  // Bit t set: term t enters the lane sum negated.
  localparam logic [N_TERM-1:0] NEG_TERM [N_LANE] = '{
    4'b1110, 4'b1000, 4'b1000, 4'b1000
  };

endpackage

// ===== hdl/quaternion_multiply_normalize_core.sv =====
// Hamilton product of two quaternions, rounded, saturated and normalised.
// Throughput one beat per cycle while the output is not stalled.
// Depth is set by the bit-per-stage square root (COMP_WIDTH stages) and the
// bit-per-stage restoring dividers (COMP_WIDTH-1 stages), four lanes wide.
// The whole pipeline holds while a finished beat waits at a stalled output.
// Synchronous active-low reset clears the valid bits only.
module quaternion_multiply_normalize_core #(
  parameter int COMP_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COMP_WIDTH-1:0] in_a_w,
  input  logic signed [COMP_WIDTH-1:0] in_a_x,
  input  logic signed [COMP_WIDTH-1:0] in_a_y,
  input  logic signed [COMP_WIDTH-1:0] in_a_z,
  input  logic signed [COMP_WIDTH-1:0] in_b_w,
  input  logic signed [COMP_WIDTH-1:0] in_b_x,
  input  logic signed [COMP_WIDTH-1:0] in_b_y,
  input  logic signed [COMP_WIDTH-1:0] in_b_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COMP_WIDTH-1:0] out_r_w,
  output logic signed [COMP_WIDTH-1:0] out_r_x,
  output logic signed [COMP_WIDTH-1:0] out_r_y,
  output logic signed [COMP_WIDTH-1:0] out_r_z,
  output logic                         out_zero_magnitude,
  output logic                         out_saturated
);
  import qmn_pkg::*;

  localparam int W   = COMP_WIDTH;
  localparam int F   = W - 2;
  localparam int PW  = 2 * W;
  localparam int SW  = 2 * W + 2;
  localparam int QW  = SW - F;
  localparam int RW  = W + 3;
  localparam int QB  = W - 1;
  localparam int SHW = $clog2(W);

  localparam logic signed [SW-1:0] RND  = SW'(64'sd1 <<< (F - 1));
  localparam logic signed [QW-1:0] QMAX = QW'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic signed [QW-1:0] QMIN = -QMAX - QW'(1);

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic signed [W-1:0] a_in [N_LANE];
  logic signed [W-1:0] b_in [N_LANE];
  assign a_in = '{in_a_w, in_a_x, in_a_y, in_a_z};
  assign b_in = '{in_b_w, in_b_x, in_b_y, in_b_z};

  // stage 1: products
  logic                 v1_r;
  logic signed [PW-1:0] prod_r [N_LANE][N_TERM];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
    if (en) begin
      for (int l = 0; l < N_LANE; l++) begin
        for (int t = 0; t < N_TERM; t++) begin
          prod_r[l][t] <= a_in[A_SEL[l][t]] * b_in[B_SEL[l][t]];
        end
      end
    end
  end

  // stage 2: lane sums
  logic                 v2_r;
  logic signed [SW-1:0] sum_r [N_LANE];
  logic signed [SW-1:0] sum_nxt [N_LANE];
  always_comb begin
    for (int l = 0; l < N_LANE; l++) begin
      sum_nxt[l] = '0;
      for (int t = 0; t < N_TERM; t++) begin
        if (NEG_TERM[l][t]) begin
          sum_nxt[l] = sum_nxt[l] - SW'(prod_r[l][t]);
        end else begin
          sum_nxt[l] = sum_nxt[l] + SW'(prod_r[l][t]);
        end
      end
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      sum_r <= sum_nxt;
    end
  end

  // stage 3: round and clip
  logic                v3_r;
  logic                sat3_r;
  logic signed [W-1:0] p3_r [N_LANE];
  logic signed [W-1:0] p3_nxt [N_LANE];
  logic                sat3_nxt;
  logic signed [SW-1:0] rs;
  logic signed [QW-1:0] rq;
  always_comb begin
    sat3_nxt = 1'b0;
    for (int l = 0; l < N_LANE; l++) begin
      rs = sum_r[l] + RND;
      rq = QW'(rs >>> F);
      if (rq > QMAX) begin
        p3_nxt[l] = W'(QMAX);
        sat3_nxt  = 1'b1;
      end else if (rq < QMIN) begin
        p3_nxt[l] = W'(QMIN);
        sat3_nxt  = 1'b1;
      end else begin
        p3_nxt[l] = W'(rq);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
    if (en) begin
      p3_r   <= p3_nxt;
      sat3_r <= sat3_nxt;
    end
  end

  // stage 4: magnitudes and largest
  logic              v4_r;
  logic              sat4_r;
  logic              zero4_r;
  logic [N_LANE-1:0] neg4_r;
  logic [W-1:0]      abs4_r [N_LANE];
  logic [W-2:0]      mm1_r;
  logic [W-1:0]      abs4_nxt [N_LANE];
  logic [W-1:0]      mx01, mx23, mx;
  always_comb begin
    for (int l = 0; l < N_LANE; l++) begin
      abs4_nxt[l] = p3_r[l][W-1] ? W'(-p3_r[l]) : W'(p3_r[l]);
    end
    mx01 = (abs4_nxt[0] > abs4_nxt[1]) ? abs4_nxt[0] : abs4_nxt[1];
    mx23 = (abs4_nxt[2] > abs4_nxt[3]) ? abs4_nxt[2] : abs4_nxt[3];
    mx   = (mx01 > mx23) ? mx01 : mx23;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
    if (en) begin
      abs4_r  <= abs4_nxt;
      sat4_r  <= sat3_r;
      zero4_r <= (mx == '0);
      mm1_r   <= (W-1)'(mx - W'(1));
      for (int l = 0; l < N_LANE; l++) begin
        neg4_r[l] <= p3_r[l][W-1];
      end
    end
  end

  // stage 5: normalising shift
  logic              v5_r;
  logic              sat5_r;
  logic              zero5_r;
  logic [N_LANE-1:0] neg5_r;
  logic [W-1:0]      abs5_r [N_LANE];
  logic [SHW-1:0]    sh;
  always_comb begin
    sh = SHW'(W - 1);
    for (int i = 0; i < W - 1; i++) begin
      if (mm1_r[i]) begin
        sh = SHW'(W - 2 - i);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
    if (en) begin
      for (int l = 0; l < N_LANE; l++) begin
        abs5_r[l] <= abs4_r[l] << sh;
      end
      neg5_r  <= neg4_r;
      zero5_r <= zero4_r;
      sat5_r  <= sat4_r;
    end
  end

  // stage 6: squares
  logic              v6_r;
  logic              sat6_r;
  logic              zero6_r;
  logic [N_LANE-1:0] neg6_r;
  logic [W-1:0]      abs6_r [N_LANE];
  logic [PW-1:0]     sq6_r [N_LANE];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= v5_r;
    end
    if (en) begin
      for (int l = 0; l < N_LANE; l++) begin
        sq6_r[l] <= abs5_r[l] * abs5_r[l];
      end
      abs6_r  <= abs5_r;
      neg6_r  <= neg5_r;
      zero6_r <= zero5_r;
      sat6_r  <= sat5_r;
    end
  end

  // stage 7 and square root pipeline: element j holds the state after j root bits
  logic              v_s_r    [0:W];
  logic              sat_s_r  [0:W];
  logic              zero_s_r [0:W];
  logic [N_LANE-1:0] neg_s_r  [0:W];
  logic [W-1:0]      abs_s_r  [0:W][N_LANE];
  logic [PW-1:0]     xs_s_r   [0:W];
  logic [RW-1:0]     rem_s_r  [0:W];
  logic [W-1:0]      root_s_r [0:W];
  logic [SW-1:0]     msum;
  assign msum = SW'(sq6_r[0]) + SW'(sq6_r[1]) + SW'(sq6_r[2]) + SW'(sq6_r[3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_s_r[0] <= 1'b0;
    end else if (en) begin
      v_s_r[0] <= v6_r;
    end
    if (en) begin
      xs_s_r[0]   <= (msum[SW-1:PW] != '0) ? '1 : msum[PW-1:0];
      rem_s_r[0]  <= '0;
      root_s_r[0] <= '0;
      abs_s_r[0]  <= abs6_r;
      neg_s_r[0]  <= neg6_r;
      zero_s_r[0] <= zero6_r;
      sat_s_r[0]  <= sat6_r;
    end
  end

  for (genvar j = 0; j < W; j++) begin : g_sqrt
    logic [RW-1:0] rn;
    logic [RW-1:0] trial;
    assign rn    = {rem_s_r[j][RW-3:0], xs_s_r[j][PW-1:PW-2]};
    assign trial = RW'({root_s_r[j], 2'b01});
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_s_r[j+1] <= 1'b0;
      end else if (en) begin
        v_s_r[j+1] <= v_s_r[j];
      end
      if (en) begin
        if (rn >= trial) begin
          rem_s_r[j+1]  <= rn - trial;
          root_s_r[j+1] <= {root_s_r[j][W-2:0], 1'b1};
        end else begin
          rem_s_r[j+1]  <= rn;
          root_s_r[j+1] <= {root_s_r[j][W-2:0], 1'b0};
        end
        xs_s_r[j+1]   <= xs_s_r[j] << 2;
        abs_s_r[j+1]  <= abs_s_r[j];
        neg_s_r[j+1]  <= neg_s_r[j];
        zero_s_r[j+1] <= zero_s_r[j];
        sat_s_r[j+1]  <= sat_s_r[j];
      end
    end
  end

  // divider pipeline: element j holds the state after j quotient bits
  logic              v_d_r    [0:QB];
  logic              sat_d_r  [0:QB];
  logic              zero_d_r [0:QB];
  logic [N_LANE-1:0] neg_d_r  [0:QB];
  logic [W:0]        den_d_r  [0:QB];
  logic [PW-1:0]     num_d_r  [0:QB][N_LANE];
  logic [QB-1:0]     quo_d_r  [0:QB][N_LANE];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_d_r[0] <= 1'b0;
    end else if (en) begin
      v_d_r[0] <= v_s_r[W];
    end
    if (en) begin
      for (int l = 0; l < N_LANE; l++) begin
        num_d_r[0][l] <= PW'({abs_s_r[W][l], {(F + 1){1'b0}}}) + PW'(root_s_r[W]);
        quo_d_r[0][l] <= '0;
      end
      den_d_r[0]  <= {root_s_r[W], 1'b0};
      neg_d_r[0]  <= neg_s_r[W];
      zero_d_r[0] <= zero_s_r[W];
      sat_d_r[0]  <= sat_s_r[W];
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [PW-1:0] dk;
    assign dk = PW'(den_d_r[j]) << (QB - 1 - j);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_d_r[j+1] <= 1'b0;
      end else if (en) begin
        v_d_r[j+1] <= v_d_r[j];
      end
      if (en) begin
        for (int l = 0; l < N_LANE; l++) begin
          if (num_d_r[j][l] >= dk) begin
            num_d_r[j+1][l] <= num_d_r[j][l] - dk;
            quo_d_r[j+1][l] <= QB'({quo_d_r[j][l], 1'b1});
          end else begin
            num_d_r[j+1][l] <= num_d_r[j][l];
            quo_d_r[j+1][l] <= QB'({quo_d_r[j][l], 1'b0});
          end
        end
        den_d_r[j+1]  <= den_d_r[j];
        neg_d_r[j+1]  <= neg_d_r[j];
        zero_d_r[j+1] <= zero_d_r[j];
        sat_d_r[j+1]  <= sat_d_r[j];
      end
    end
  end

  // output register
  logic                out_valid_r;
  logic                zero_r;
  logic                sat_r;
  logic signed [W-1:0] res_r [N_LANE];
  logic signed [W-1:0] res_nxt [N_LANE];
  logic signed [W-1:0] qx;
  always_comb begin
    for (int l = 0; l < N_LANE; l++) begin
      qx = W'(quo_d_r[QB][l]);
      if (zero_d_r[QB]) begin
        res_nxt[l] = '0;
      end else if (neg_d_r[QB][l]) begin
        res_nxt[l] = -qx;
      end else begin
        res_nxt[l] = qx;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_d_r[QB];
    end
    if (en) begin
      res_r  <= res_nxt;
      zero_r <= zero_d_r[QB];
      sat_r  <= sat_d_r[QB];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_r_w            = res_r[0];
  assign out_r_x            = res_r[1];
  assign out_r_y            = res_r[2];
  assign out_r_z            = res_r[3];
  assign out_zero_magnitude = zero_r;
  assign out_saturated      = sat_r;

endmodule

// ===== dv/quaternion_multiply_normalize_core_tb.sv =====
// Self-checking testbench for the quaternion multiply and normalize core.
`timescale 1ns / 1ps
module quaternion_multiply_normalize_core_tb;

  localparam int CW = 16;
  localparam int FRAC = CW - 2;
  localparam int LATENCY = 2 * CW + 8;
  localparam int WATCHDOG = 20000;

  typedef logic signed [CW-1:0] comp_t;
  typedef struct packed {
    comp_t aw, ax, ay, az, bw, bx, by, bz;
  } qpair_t;
  typedef struct packed {
    comp_t rw, rx, ry, rz;
    logic zm, sat;
  } qres_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  comp_t in_a_w, in_a_x, in_a_y, in_a_z, in_b_w, in_b_x, in_b_y, in_b_z;
  comp_t out_r_w, out_r_x, out_r_y, out_r_z;
  logic out_zero_magnitude, out_saturated;

  quaternion_multiply_normalize_core #(.COMP_WIDTH(CW)) dut (.*);

  qpair_t pending_pairs[$];
  qres_t expected_products[$];
  int errors = 0;
  int idle_cycles = 0;
  int in_gap = 0, out_gap = 0;
  bit hold_for_drain = 0;
  bit stimulus_done = 0;

  function automatic longint round_clip(longint s, ref bit sat);
    longint v;
    v = (s + (longint'(1) << (FRAC - 1))) >>> FRAC;
    if (v > 32767) begin sat = 1; v = 32767; end
    if (v < -32768) begin sat = 1; v = -32768; end
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else res >>= 1;
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic qres_t hamilton_normalized(qpair_t q);
    longint aw, ax, ay, az, bw, bx, by, bz;
    longint p[4];
    longint unsigned absv[4], m, half, mag2, mag, n, qv;
    int sh;
    bit sat;
    qres_t r;
    aw = longint'(q.aw); ax = longint'(q.ax); ay = longint'(q.ay); az = longint'(q.az);
    bw = longint'(q.bw); bx = longint'(q.bx); by = longint'(q.by); bz = longint'(q.bz);
    sat = 0;
    p[0] = round_clip(aw*bw - ax*bx - ay*by - az*bz, sat);
    p[1] = round_clip(aw*bx + bw*ax + ay*bz - az*by, sat);
    p[2] = round_clip(aw*by + bw*ay + az*bx - ax*bz, sat);
    p[3] = round_clip(aw*bz + bw*az + ax*by - ay*bx, sat);
    m = 0;
    for (int i = 0; i < 4; i++) begin
      absv[i] = p[i] < 0 ? -p[i] : p[i];
      if (absv[i] > m) m = absv[i];
    end
    r = '0;
    r.sat = sat;
    if (m == 0) begin
      r.zm = 1'b1;
      return r;
    end
    half = 64'd1 << (CW - 1);
    sh = 0;
    while ((m << 1) <= half) begin m <<= 1; sh++; end
    mag2 = 0;
    for (int i = 0; i < 4; i++) begin
      absv[i] <<= sh;
      mag2 += absv[i] * absv[i];
    end
    mag = int_sqrt(mag2);
    for (int i = 0; i < 4; i++) begin
      longint sv;
      n = absv[i] << FRAC;
      qv = (2 * n + mag) / (2 * mag);
      sv = p[i] < 0 ? -longint'(qv) : longint'(qv);
      if (sv > 32767) sv = 32767;
      if (sv < -32768) sv = -32768;
      p[i] = sv;
    end
    r.rw = comp_t'(p[0]);
    r.rx = comp_t'(p[1]);
    r.ry = comp_t'(p[2]);
    r.rz = comp_t'(p[3]);
    return r;
  endfunction

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 45) return 0;
    if (k < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic comp_t rand_comp();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh4000;
      3: return 16'shc000;
      4: return 16'sh0000;
      5: return comp_t'(int'($urandom_range(0, 15)) - 8);
      default: return comp_t'($urandom);
    endcase
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    qpair_t q;
    comp_t ext[4];
    ext = '{16'sh7fff, 16'sh8000, 16'sh4000, 16'shc000};
    q = '0; pending_pairs.push_back(q);
    q.aw = 16'sh4000; q.bw = 16'sh4000; pending_pairs.push_back(q);
    q = {8{16'sh7fff}}; pending_pairs.push_back(q);
    q = {8{16'sh8000}}; pending_pairs.push_back(q);
    q = {16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
         16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff};
    pending_pairs.push_back(q);
    q = '0; q.aw = 16'sh0001; q.bw = 16'sh0001; pending_pairs.push_back(q);
    q = '0; q.aw = 16'sh0080; q.bw = 16'sh0080; pending_pairs.push_back(q);
    q = '0; q.ax = 16'sh4000; q.by = 16'sh4000; pending_pairs.push_back(q);
    q = '0; q.ay = 16'sh4000; q.bz = 16'sh4000; pending_pairs.push_back(q);
    q = '0; q.az = 16'sh4000; q.bx = 16'sh4000; pending_pairs.push_back(q);
    q = '0; q.aw = 16'sh2d41; q.ax = 16'sh2d41; q.bw = 16'sh2d41; q.bz = 16'shd2bf;
    pending_pairs.push_back(q);
    q = {8{16'shffff}}; pending_pairs.push_back(q);
    for (int i = 0; i < 8; i++) begin
      q = '0;
      q.aw = ext[i % 4]; q.bx = ext[(i + 1) % 4]; q.ay = ext[(i + 2) % 4];
      q.bz = ext[(i + 3) % 4];
      pending_pairs.push_back(q);
    end
    for (int i = 0; i < 1050; i++) begin
      q = {rand_comp(), rand_comp(), rand_comp(), rand_comp(),
           rand_comp(), rand_comp(), rand_comp(), rand_comp()};
      if ($urandom_range(0, 3) == 0) q = {8{comp_t'($urandom)}} ^ {8{comp_t'($urandom)}};
      if ($urandom_range(0, 3) == 0) q = {$urandom, $urandom, $urandom, $urandom};
      pending_pairs.push_back(q);
    end
    stimulus_done = 1;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
      {in_a_w, in_a_x, in_a_y, in_a_z, in_b_w, in_b_x, in_b_y, in_b_z} <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_products.push_back(hamilton_normalized(
          {in_a_w, in_a_x, in_a_y, in_a_z, in_b_w, in_b_x, in_b_y, in_b_z}));
        if (pending_pairs.size() == 520) hold_for_drain <= 1;
      end
      if (!(in_valid && in_stall)) begin
        if (hold_for_drain) begin
          in_valid <= 0;
          if (expected_products.size() == 0 && !(in_valid && !in_stall))
            hold_for_drain <= 0;
        end else if (in_gap > 0) begin
          in_valid <= 0;
          in_gap <= in_gap - 1;
        end else if (pending_pairs.size() > 0) begin
          qpair_t q;
          q = pending_pairs.pop_front();
          {in_a_w, in_a_x, in_a_y, in_a_z, in_b_w, in_b_x, in_b_y, in_b_z} <= q;
          in_valid <= 1;
          in_gap <= pick_gap();
        end else in_valid <= 0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1;
    end else begin
      if (out_valid && !out_stall) begin
        qres_t e;
        if (expected_products.size() == 0) begin
          $error("unexpected beat");
          errors++;
        end else begin
          e = expected_products.pop_front();
          if (out_r_w !== e.rw) begin
            $error("r_w exp %0d got %0d", e.rw, out_r_w); errors++;
          end
          if (out_r_x !== e.rx) begin
            $error("r_x exp %0d got %0d", e.rx, out_r_x); errors++;
          end
          if (out_r_y !== e.ry) begin
            $error("r_y exp %0d got %0d", e.ry, out_r_y); errors++;
          end
          if (out_r_z !== e.rz) begin
            $error("r_z exp %0d got %0d", e.rz, out_r_z); errors++;
          end
          if (out_zero_magnitude !== e.zm) begin
            $error("zero_magnitude exp %0b got %0b", e.zm, out_zero_magnitude); errors++;
          end
          if (out_saturated !== e.sat) begin
            $error("saturated exp %0b got %0b", e.sat, out_saturated); errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_stall <= 1;
        out_gap <= out_gap - 1;
      end else begin
        out_stall <= 0;
        if ($urandom_range(0, 3) == 0) out_gap <= pick_gap();
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    while (!(stimulus_done && pending_pairs.size() == 0 && !in_valid
             && expected_products.size() == 0)) begin
      @(posedge clk);
      if (idle_cycles >= WATCHDOG) begin
        $display("quaternion_multiply_normalize_core_tb: errors");
        $finish;
      end
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && expected_products.size() == 0)
      $display("quaternion_multiply_normalize_core_tb: clean");
    else
      $display("quaternion_multiply_normalize_core_tb: errors");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/qmn_pkg.sv
hdl/quaternion_multiply_normalize_core.sv
dv/quaternion_multiply_normalize_core_tb.sv
